### rtl/ini_config_tokenizer_core_defines.svh
// assertion macros for the ini config tokenizer
`ifndef INI_CONFIG_TOKENIZER_CORE_DEFINES_SVH
`define INI_CONFIG_TOKENIZER_CORE_DEFINES_SVH
`ifndef SYNTH
`define ICT_ASSERT(lbl, clk, rst, prop) \
lbl: assert property (@(posedge clk) disable iff (rst) prop) \
   else $error("ict assertion failed");
`define ICT_NEVER(lbl, clk, rst, expr) \
lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
   else $error("ict forbidden condition");
`else
`define ICT_ASSERT(lbl, clk, rst, prop)
`define ICT_NEVER(lbl, clk, rst, expr)
`endif
`endif

### rtl/ict_pkg.sv
// types, constants and byte classifier for the ini config tokenizer
`timescale 1ns / 1ps
package ict_pkg;

   localparam int LINE_BITS_DEF   = 16;
   localparam int COLUMN_BITS_DEF = 16;
   localparam int QUEUE_DEPTH     = 2;
   localparam int POS_OUT_W       = 16;

   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_VT      = 8'h0B;
   localparam logic [7:0] CH_FF      = 8'h0C;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_LOW_A   = 8'h61;
   localparam logic [7:0] CH_LOW_Z   = 8'h7A;
   localparam logic [7:0] CH_UP_A    = 8'h41;
   localparam logic [7:0] CH_UP_Z    = 8'h5A;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_DASH    = 8'h2D;
   localparam logic [7:0] CH_UNDER   = 8'h5F;
   localparam logic [7:0] CH_EQUALS  = 8'h3D;
   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_OPEN    = 8'h5B;
   localparam logic [7:0] CH_CLOSE   = 8'h5D;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_BSLASH  = 8'h5C;

   typedef enum logic [3:0] {
      K_SPACE, K_DIGIT, K_ALPHA, K_DASH, K_EQ, K_QUOTE, K_OPEN, K_CLOSE,
      K_HASH, K_BSLASH, K_EOL, K_OTHER
   } kind_type;

   typedef enum logic [3:0] {
      ST_EXPECT_NAME, ST_SECTION, ST_NAME, ST_COMMENT, ST_EXPECT_EQ,
      ST_EXPECT_VALUE, ST_VALUE, ST_QUOTED, ST_EXPECT_EOL
   } parse_state_type;

   typedef enum logic [2:0] {
      R_NONE, R_CLR_SEC, R_APP_SEC, R_START_NAME, R_APP_NAME, R_CLR_VAL,
      R_START_VAL, R_APP_VAL
   } role_type;

   typedef enum logic [2:0] {
      E_NAME, E_CLOSE, E_EQ, E_VALUE, E_EOL, E_QUOTE
   } err_type;

   typedef struct packed {
      logic       action;
      logic [7:0] byte_value;
      kind_type   kind;
   } item_type;

   typedef struct packed {
      role_type               text_role;
      logic [7:0]             text_char;
      logic                   commit_item;
      logic                   error_flag;
      err_type                error_kind;
      logic                   parser_halted;
      logic [POS_OUT_W-1:0]   line_number;
      logic [POS_OUT_W-1:0]   column_number;
   } rsp_type;

   function automatic kind_type classify(input logic [7:0] b);
      kind_type k;
      case (b) inside
         CH_NEWLINE:                            k = K_EOL;
         CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR: k = K_SPACE;
         [CH_LOW_A:CH_LOW_Z], [CH_UP_A:CH_UP_Z]: k = K_ALPHA;
         [CH_ZERO:CH_NINE]:                     k = K_DIGIT;
         CH_DASH, CH_UNDER:                     k = K_DASH;
         CH_EQUALS:                             k = K_EQ;
         CH_QUOTE:                              k = K_QUOTE;
         CH_OPEN:                               k = K_OPEN;
         CH_CLOSE:                              k = K_CLOSE;
         CH_HASH:                               k = K_HASH;
         CH_BSLASH:                             k = K_BSLASH;
         default:                               k = K_OTHER;
      endcase
      return k;
   endfunction

endpackage

### rtl/ict_queue.sv
// small register queue between pipeline parts
`timescale 1ns / 1ps
`include "ini_config_tokenizer_core_defines.svh"
module ict_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);
   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] CNT_ONE  = CNT_BITS'(1);
   localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == CNT_FULL);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_ONE;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   `ICT_NEVER(a_count_range, clock, reset, count_ff > CNT_FULL)
   `ICT_ASSERT(a_count_up, clock, reset, do_push && !do_pop |=> count_ff == $past(count_ff) + CNT_ONE)
   `ICT_ASSERT(a_count_down, clock, reset, do_pop && !do_push |=> count_ff == $past(count_ff) - CNT_ONE)

endmodule

### rtl/ict_front.sv
// front part: takes raw bytes and classifies them
`timescale 1ns / 1ps
module ict_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic              req_action,
   input  logic [7:0]        req_byte_value,
   output logic              item_valid,
   output ict_pkg::item_type item_data,
   input  logic              item_ready
);
   import ict_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff;
   logic     load;

   assign full       = valid_ff && !item_ready;
   assign load       = push && !full;
   assign item_valid = valid_ff;
   assign item_data  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (item_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.action     <= req_action;
         item_ff.byte_value <= req_byte_value;
         item_ff.kind       <= classify(req_byte_value);
      end
   end

endmodule

### rtl/ict_back.sv
// back part: parse state machine, line and column counters
`timescale 1ns / 1ps
`include "ini_config_tokenizer_core_defines.svh"
module ict_back #(
   parameter int LINE_BITS   = ict_pkg::LINE_BITS_DEF,
   parameter int COLUMN_BITS = ict_pkg::COLUMN_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  ict_pkg::item_type item,
   output logic              take,
   input  logic              rsp_full,
   output ict_pkg::rsp_type  rsp
);
   import ict_pkg::*;

   localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);

   parse_state_type        state_ff, state_in;
   logic                   esc_ff, esc_in;
   logic                   halt_ff, halt_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [COLUMN_BITS-1:0] col_ff, col_in;
   logic [COLUMN_BITS-1:0] col_inc, col_view;
   logic                   name_like;
   role_type               role;
   logic                   commit, err;
   err_type                kind;

   assign take      = item_valid && !rsp_full;
   assign name_like = (item.kind == K_ALPHA) || (item.kind == K_DIGIT) ||
                      (item.kind == K_DASH);
   assign col_inc   = (col_ff != '1) ? col_ff + COLUMN_BITS'(1) : col_ff;

   always_comb begin
      state_in = state_ff;
      esc_in   = esc_ff;
      halt_in  = halt_ff;
      line_in  = line_ff;
      col_in   = col_ff;
      col_view = col_ff;
      role     = R_NONE;
      commit   = 1'b0;
      err      = 1'b0;
      kind     = E_NAME;
      if (item.action) begin
         if (!halt_ff) begin
            if (state_ff == ST_QUOTED) begin
               err  = 1'b1;
               kind = E_QUOTE;
            end else if (state_ff == ST_VALUE) begin
               commit = 1'b1;
            end
         end
         state_in = ST_EXPECT_NAME;
         esc_in   = 1'b0;
         halt_in  = 1'b0;
         line_in  = LINE_ONE;
         col_in   = '0;
      end else if (!halt_ff) begin
         col_view = col_inc;
         col_in   = col_inc;
         case (state_ff)
            ST_EXPECT_NAME: begin
               if (name_like) begin
                  state_in = ST_NAME;
                  role     = R_START_NAME;
               end else if (item.kind == K_OPEN) begin
                  state_in = ST_SECTION;
                  role     = R_CLR_SEC;
               end else if (item.kind == K_SPACE || item.kind == K_EOL) begin
                  state_in = ST_EXPECT_NAME;
               end else if (item.kind == K_HASH) begin
                  state_in = ST_COMMENT;
               end else begin
                  err  = 1'b1;
                  kind = E_NAME;
               end
            end
            ST_SECTION: begin
               if (item.kind == K_ALPHA || item.kind == K_DIGIT) begin
                  role = R_APP_SEC;
               end else if (item.kind == K_CLOSE) begin
                  state_in = ST_EXPECT_EOL;
               end else begin
                  err  = 1'b1;
                  kind = E_CLOSE;
               end
            end
            ST_NAME: begin
               if (name_like) begin
                  role = R_APP_NAME;
               end else if (item.kind == K_EQ) begin
                  state_in = ST_EXPECT_VALUE;
               end else if (item.kind == K_SPACE) begin
                  state_in = ST_EXPECT_EQ;
               end else begin
                  err  = 1'b1;
                  kind = E_EQ;
               end
            end
            ST_COMMENT: begin
               if (item.kind == K_EOL) begin
                  state_in = ST_EXPECT_NAME;
               end
            end
            ST_EXPECT_EQ: begin
               if (item.kind == K_EQ) begin
                  state_in = ST_EXPECT_VALUE;
               end else if (item.kind != K_SPACE) begin
                  err  = 1'b1;
                  kind = E_EQ;
               end
            end
            ST_EXPECT_VALUE: begin
               if (name_like) begin
                  state_in = ST_VALUE;
                  role     = R_START_VAL;
               end else if (item.kind == K_QUOTE) begin
                  state_in = ST_QUOTED;
                  role     = R_CLR_VAL;
               end else if (item.kind != K_SPACE) begin
                  err  = 1'b1;
                  kind = E_VALUE;
               end
            end
            ST_VALUE: begin
               if (item.kind == K_QUOTE) begin
                  err  = 1'b1;
                  kind = E_VALUE;
               end else if (item.kind == K_SPACE) begin
                  state_in = ST_EXPECT_EOL;
                  commit   = 1'b1;
               end else if (item.kind == K_EOL) begin
                  state_in = ST_EXPECT_NAME;
                  commit   = 1'b1;
               end else if (item.kind == K_HASH) begin
                  state_in = ST_COMMENT;
                  commit   = 1'b1;
               end else begin
                  role = R_APP_VAL;
               end
            end
            ST_QUOTED: begin
               if (esc_ff) begin
                  role   = R_APP_VAL;
                  esc_in = 1'b0;
               end else if (item.kind == K_QUOTE) begin
                  state_in = ST_EXPECT_EOL;
                  commit   = 1'b1;
               end else if (item.kind == K_BSLASH) begin
                  esc_in = 1'b1;
               end else begin
                  role = R_APP_VAL;
               end
            end
            ST_EXPECT_EOL: begin
               if (item.kind == K_HASH) begin
                  state_in = ST_COMMENT;
               end else if (item.kind == K_EOL) begin
                  state_in = ST_EXPECT_NAME;
               end else if (item.kind != K_SPACE) begin
                  err  = 1'b1;
                  kind = E_EOL;
               end
            end
            default: begin
               state_in = state_ff;
            end
         endcase
         if (err) begin
            halt_in = 1'b1;
         end else if (item.kind == K_EOL) begin
            line_in = (line_ff != '1) ? line_ff + LINE_ONE : line_ff;
            col_in  = '0;
         end
      end
   end

   always_comb begin
      rsp.text_role     = role;
      rsp.text_char     = (role != R_NONE && role != R_CLR_SEC && role != R_CLR_VAL) ?
                          item.byte_value : 8'h00;
      rsp.commit_item   = commit;
      rsp.error_flag    = err;
      rsp.error_kind    = kind;
      rsp.parser_halted = halt_ff;
      rsp.line_number   = POS_OUT_W'(line_ff);
      rsp.column_number = POS_OUT_W'(col_view);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_EXPECT_NAME;
         esc_ff   <= 1'b0;
         halt_ff  <= 1'b0;
         line_ff  <= LINE_ONE;
         col_ff   <= '0;
      end else if (take) begin
         state_ff <= state_in;
         esc_ff   <= esc_in;
         halt_ff  <= halt_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
      end
   end

   `ICT_ASSERT(a_err_quiet, clock, reset, take && rsp.error_flag |-> rsp.text_role == R_NONE && !rsp.commit_item && !halt_ff)
   `ICT_ASSERT(a_halt_frozen, clock, reset, take && halt_ff && !item.action |=> $stable(line_ff) && $stable(col_ff))
   `ICT_ASSERT(a_eos_clears, clock, reset, take && item.action |=> state_ff == ST_EXPECT_NAME && !halt_ff && line_ff == LINE_ONE)

endmodule

### rtl/ini_config_tokenizer_core.sv
// top level of the ini config tokenizer
//
//   channel   handshake           payload
//   input     push / full         req_action, req_byte_value
//   result    pop / empty         rsp_text_role .. rsp_column_number
//
// one item per cycle sustained while results are popped; a taken item passes
// the front register, the middle queue and the result queue, in that order
// the parse state machine is combinational and handles a byte as it is taken
// synchronous reset, no clearing pass; full rises once front and mid queue fill
`timescale 1ns / 1ps
module ini_config_tokenizer_core #(
   parameter int LINE_BITS   = ict_pkg::LINE_BITS_DEF,
   parameter int COLUMN_BITS = ict_pkg::COLUMN_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_action,
   input  logic [7:0]  req_byte_value,
   output logic        empty,
   input  logic        pop,
   output logic [2:0]  rsp_text_role,
   output logic [7:0]  rsp_text_char,
   output logic        rsp_commit_item,
   output logic        rsp_error_flag,
   output logic [2:0]  rsp_error_kind,
   output logic        rsp_parser_halted,
   output logic [15:0] rsp_line_number,
   output logic [15:0] rsp_column_number
);
   import ict_pkg::*;

   logic     front_valid, mid_full, mid_empty, take, out_full;
   item_type front_item, mid_item;
   rsp_type  back_rsp, out_rsp;

   ict_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_action     (req_action),
      .req_byte_value (req_byte_value),
      .item_valid     (front_valid),
      .item_data      (front_item),
      .item_ready     (!mid_full)
   );

   ict_queue #(
      .WIDTH ($bits(item_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_mid_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (front_valid),
      .wr_data (front_item),
      .full    (mid_full),
      .pop     (take),
      .rd_data (mid_item),
      .empty   (mid_empty)
   );

   ict_back #(
      .LINE_BITS   (LINE_BITS),
      .COLUMN_BITS (COLUMN_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (!mid_empty),
      .item       (mid_item),
      .take       (take),
      .rsp_full   (out_full),
      .rsp        (back_rsp)
   );

   ict_queue #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (take),
      .wr_data (back_rsp),
      .full    (out_full),
      .pop     (pop),
      .rd_data (out_rsp),
      .empty   (empty)
   );

   assign rsp_text_role     = out_rsp.text_role;
   assign rsp_text_char     = out_rsp.text_char;
   assign rsp_commit_item   = out_rsp.commit_item;
   assign rsp_error_flag    = out_rsp.error_flag;
   assign rsp_error_kind    = out_rsp.error_kind;
   assign rsp_parser_halted = out_rsp.parser_halted;
   assign rsp_line_number   = out_rsp.line_number;
   assign rsp_column_number = out_rsp.column_number;

endmodule

### tb/ini_config_tokenizer_checker.sv
// checker for the ini config tokenizer: watches both channels, predicts each result and compares
`timescale 1ns / 1ps
module ini_config_tokenizer_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic        full,
   input  logic        req_action,
   input  logic [7:0]  req_byte_value,
   input  logic        empty,
   input  logic        pop,
   input  logic [2:0]  rsp_text_role,
   input  logic [7:0]  rsp_text_char,
   input  logic        rsp_commit_item,
   input  logic        rsp_error_flag,
   input  logic [2:0]  rsp_error_kind,
   input  logic        rsp_parser_halted,
   input  logic [15:0] rsp_line_number,
   input  logic [15:0] rsp_column_number,
   output int          fail_count,
   output int          pending_count
);
   import ict_pkg::*;

   parse_state_type                tok_state;
   logic                           esc_pend;
   logic                           halted;
   logic [LINE_BITS_DEF-1:0]       line_cnt;
   logic [COLUMN_BITS_DEF-1:0]     col_cnt;
   rsp_type                        expected_tokens[$];

   function automatic kind_type byte_kind(input logic [7:0] b);
      if (b == CH_NEWLINE) return K_EOL;
      if (b inside {CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR}) return K_SPACE;
      if (b inside {[CH_LOW_A:CH_LOW_Z], [CH_UP_A:CH_UP_Z]}) return K_ALPHA;
      if (b inside {[CH_ZERO:CH_NINE]}) return K_DIGIT;
      if (b == CH_DASH || b == CH_UNDER) return K_DASH;
      if (b == CH_EQUALS) return K_EQ;
      if (b == CH_QUOTE) return K_QUOTE;
      if (b == CH_OPEN) return K_OPEN;
      if (b == CH_CLOSE) return K_CLOSE;
      if (b == CH_HASH) return K_HASH;
      if (b == CH_BSLASH) return K_BSLASH;
      return K_OTHER;
   endfunction

   function automatic void clear_parser();
      tok_state = ST_EXPECT_NAME;
      esc_pend  = 1'b0;
      halted    = 1'b0;
      line_cnt  = LINE_BITS_DEF'(1);
      col_cnt   = '0;
   endfunction

   function automatic rsp_type predict_token(input logic act, input logic [7:0] b);
      rsp_type  r;
      kind_type k;
      logic     word;
      logic     was_halted;
      r = '0;
      was_halted = halted;
      if (act) begin
         if (!was_halted) begin
            if (tok_state == ST_QUOTED) begin
               r.error_flag = 1'b1;
               r.error_kind = E_QUOTE;
            end else if (tok_state == ST_VALUE) begin
               r.commit_item = 1'b1;
            end
         end
      end else if (!was_halted) begin
         if (col_cnt != '1) col_cnt++;
         k = byte_kind(b);
         word = (k == K_ALPHA || k == K_DIGIT || k == K_DASH);
         case (tok_state)
            ST_EXPECT_NAME: begin
               if (word) begin
                  tok_state = ST_NAME;
                  r.text_role = R_START_NAME;
               end else if (k == K_OPEN) begin
                  tok_state = ST_SECTION;
                  r.text_role = R_CLR_SEC;
               end else if (k == K_HASH) begin
                  tok_state = ST_COMMENT;
               end else if (k != K_SPACE && k != K_EOL) begin
                  r.error_flag = 1'b1;
                  r.error_kind = E_NAME;
               end
            end
            ST_SECTION: begin
               if (k == K_ALPHA || k == K_DIGIT) begin
                  r.text_role = R_APP_SEC;
               end else if (k == K_CLOSE) begin
                  tok_state = ST_EXPECT_EOL;
               end else begin
                  r.error_flag = 1'b1;
                  r.error_kind = E_CLOSE;
               end
            end
            ST_NAME: begin
               if (word) begin
                  r.text_role = R_APP_NAME;
               end else if (k == K_EQ) begin
                  tok_state = ST_EXPECT_VALUE;
               end else if (k == K_SPACE) begin
                  tok_state = ST_EXPECT_EQ;
               end else begin
                  r.error_flag = 1'b1;
                  r.error_kind = E_EQ;
               end
            end
            ST_COMMENT: begin
               if (k == K_EOL) tok_state = ST_EXPECT_NAME;
            end
            ST_EXPECT_EQ: begin
               if (k == K_EQ) begin
                  tok_state = ST_EXPECT_VALUE;
               end else if (k != K_SPACE) begin
                  r.error_flag = 1'b1;
                  r.error_kind = E_EQ;
               end
            end
            ST_EXPECT_VALUE: begin
               if (word) begin
                  tok_state = ST_VALUE;
                  r.text_role = R_START_VAL;
               end else if (k == K_QUOTE) begin
                  tok_state = ST_QUOTED;
                  r.text_role = R_CLR_VAL;
               end else if (k != K_SPACE) begin
                  r.error_flag = 1'b1;
                  r.error_kind = E_VALUE;
               end
            end
            ST_VALUE: begin
               if (k == K_QUOTE) begin
                  r.error_flag = 1'b1;
                  r.error_kind = E_VALUE;
               end else if (k == K_SPACE) begin
                  tok_state = ST_EXPECT_EOL;
                  r.commit_item = 1'b1;
               end else if (k == K_EOL) begin
                  tok_state = ST_EXPECT_NAME;
                  r.commit_item = 1'b1;
               end else if (k == K_HASH) begin
                  tok_state = ST_COMMENT;
                  r.commit_item = 1'b1;
               end else begin
                  r.text_role = R_APP_VAL;
               end
            end
            ST_QUOTED: begin
               if (esc_pend) begin
                  r.text_role = R_APP_VAL;
                  esc_pend = 1'b0;
               end else if (k == K_QUOTE) begin
                  tok_state = ST_EXPECT_EOL;
                  r.commit_item = 1'b1;
               end else if (k == K_BSLASH) begin
                  esc_pend = 1'b1;
               end else begin
                  r.text_role = R_APP_VAL;
               end
            end
            ST_EXPECT_EOL: begin
               if (k == K_HASH) begin
                  tok_state = ST_COMMENT;
               end else if (k == K_EOL) begin
                  tok_state = ST_EXPECT_NAME;
               end else if (k != K_SPACE) begin
                  r.error_flag = 1'b1;
                  r.error_kind = E_EOL;
               end
            end
            default: begin
            end
         endcase
         if (r.error_flag) halted = 1'b1;
      end
      if (r.text_role inside {R_APP_SEC, R_START_NAME, R_APP_NAME, R_START_VAL, R_APP_VAL})
         r.text_char = b;
      r.parser_halted = was_halted;
      r.line_number   = line_cnt;
      r.column_number = col_cnt;
      if (act) begin
         clear_parser();
      end else if (!was_halted && !r.error_flag && b == CH_NEWLINE) begin
         if (line_cnt != '1) line_cnt++;
         col_cnt = '0;
      end
      return r;
   endfunction

   task automatic check_field(input string fname, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         clear_parser();
         expected_tokens.delete();
         fail_count = 0;
      end else begin
         if (push && !full)
            expected_tokens.push_back(predict_token(req_action, req_byte_value));
         if (pop && !empty) begin
            if (expected_tokens.size() == 0) begin
               $display("%0t ns: unexpected item, expected none, actual role %0d line %0d col %0d",
                        $time, rsp_text_role, rsp_line_number, rsp_column_number);
               fail_count++;
            end else begin
               want = expected_tokens.pop_front();
               check_field("text_role", want.text_role, rsp_text_role);
               check_field("text_char", want.text_char, rsp_text_char);
               check_field("commit_item", want.commit_item, rsp_commit_item);
               check_field("error_flag", want.error_flag, rsp_error_flag);
               check_field("error_kind", want.error_kind, rsp_error_kind);
               check_field("parser_halted", want.parser_halted, rsp_parser_halted);
               check_field("line_number", want.line_number, rsp_line_number);
               check_field("column_number", want.column_number, rsp_column_number);
            end
         end
      end
      pending_count = expected_tokens.size();
   end

endmodule

### tb/ini_config_tokenizer_core_tb.sv
// testbench top for the ini config tokenizer: text stimulus, handshake pacing and verdict
`timescale 1ns / 1ps
module ini_config_tokenizer_core_tb;
   import ict_pkg::*;

   localparam logic ACT_BYTE      = 1'b0;
   localparam logic ACT_EOS       = 1'b1;
   localparam int   HOLD_CYCLES   = 200;
   localparam int   PHASE_ITEMS   = 510;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        push           = 1'b0;
   logic        pop            = 1'b0;
   logic        req_action     = 1'b0;
   logic [7:0]  req_byte_value = 8'h00;
   logic        full;
   logic        empty;
   logic [2:0]  rsp_text_role;
   logic [7:0]  rsp_text_char;
   logic        rsp_commit_item;
   logic        rsp_error_flag;
   logic [2:0]  rsp_error_kind;
   logic        rsp_parser_halted;
   logic [15:0] rsp_line_number;
   logic [15:0] rsp_column_number;
   int          fail_count;
   int          pending_count;

   int          tx_idle     = 0;
   int          rx_idle     = 0;
   bit          rx_hold_req = 1'b0;
   bit          doc_broken  = 1'b0;
   int          phase_items = 0;

   ini_config_tokenizer_core dut (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_action        (req_action),
      .req_byte_value    (req_byte_value),
      .empty             (empty),
      .pop               (pop),
      .rsp_text_role     (rsp_text_role),
      .rsp_text_char     (rsp_text_char),
      .rsp_commit_item   (rsp_commit_item),
      .rsp_error_flag    (rsp_error_flag),
      .rsp_error_kind    (rsp_error_kind),
      .rsp_parser_halted (rsp_parser_halted),
      .rsp_line_number   (rsp_line_number),
      .rsp_column_number (rsp_column_number)
   );

   ini_config_tokenizer_checker tok_check (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_action        (req_action),
      .req_byte_value    (req_byte_value),
      .empty             (empty),
      .pop               (pop),
      .rsp_text_role     (rsp_text_role),
      .rsp_text_char     (rsp_text_char),
      .rsp_commit_item   (rsp_commit_item),
      .rsp_error_flag    (rsp_error_flag),
      .rsp_error_kind    (rsp_error_kind),
      .rsp_parser_halted (rsp_parser_halted),
      .rsp_line_number   (rsp_line_number),
      .rsp_column_number (rsp_column_number),
      .fail_count        (fail_count),
      .pending_count     (pending_count)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   task automatic send_item(input logic act, input logic [7:0] b);
      while ($urandom_range(99) < tx_idle) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push           <= 1'b1;
      req_action     <= act;
      req_byte_value <= b;
      do @(posedge clock); while (full);
      phase_items++;
   endtask

   task automatic drain();
      push <= 1'b0;
      @(posedge clock);
      wait (pending_count == 0);
   endtask

   task automatic put_string(input string s);
      for (int i = 0; i < s.len(); i++) send_item(ACT_BYTE, s[i]);
   endtask

   // occasionally corrupt the text with a stray byte or an early end of stream
   task automatic put_text(input logic [7:0] b);
      if (!doc_broken && $urandom_range(199) < 3) begin
         doc_broken = 1'b1;
         if ($urandom_range(3) == 0) send_item(ACT_EOS, 8'($urandom_range(255)));
         else send_item(ACT_BYTE, 8'($urandom_range(255)));
      end else begin
         send_item(ACT_BYTE, b);
      end
   endtask

   function automatic logic [7:0] pick_space();
      case ($urandom_range(4))
         0: return CH_SPACE;
         1: return CH_TAB;
         2: return CH_VT;
         3: return CH_FF;
         default: return CH_CR;
      endcase
   endfunction

   function automatic logic [7:0] pick_alnum();
      case ($urandom_range(2))
         0: return CH_LOW_A + 8'($urandom_range(25));
         1: return CH_UP_A + 8'($urandom_range(25));
         default: return CH_ZERO + 8'($urandom_range(9));
      endcase
   endfunction

   function automatic logic [7:0] pick_word_char();
      if ($urandom_range(3) != 0) return pick_alnum();
      return $urandom_range(1) ? CH_DASH : CH_UNDER;
   endfunction

   function automatic logic [7:0] pick_value_char();
      logic [7:0] b;
      do b = 8'($urandom_range(255));
      while (b inside {CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR, CH_NEWLINE, CH_HASH, CH_QUOTE});
      return b;
   endfunction

   function automatic logic [7:0] pick_quoted_char();
      logic [7:0] b;
      do b = 8'($urandom_range(255)); while (b == CH_QUOTE || b == CH_BSLASH);
      return b;
   endfunction

   function automatic logic [7:0] pick_comment_char();
      logic [7:0] b;
      do b = 8'($urandom_range(255)); while (b == CH_NEWLINE);
      return b;
   endfunction

   task automatic put_spaces(input int lo, input int hi);
      repeat ($urandom_range(hi, lo)) put_text(pick_space());
   endtask

   task automatic put_comment();
      put_text(CH_HASH);
      repeat ($urandom_range(6)) put_text(pick_comment_char());
   endtask

   task automatic put_line_end();
      case ($urandom_range(3))
         2: put_spaces(1, 2);
         3: begin
            put_spaces(0, 2);
            put_comment();
         end
         default: begin
         end
      endcase
      put_text(CH_NEWLINE);
   endtask

   task automatic put_setting(input bit last);
      bit cut;
      put_text(pick_word_char());
      repeat ($urandom_range(4)) put_text(pick_word_char());
      put_spaces(0, 2);
      put_text(CH_EQUALS);
      put_spaces(0, 2);
      cut = last && $urandom_range(3) == 0;
      if ($urandom_range(2) == 0) begin
         put_text(CH_QUOTE);
         repeat ($urandom_range(6)) begin
            if ($urandom_range(4) == 0) begin
               put_text(CH_BSLASH);
               put_text(8'($urandom_range(255)));
            end else begin
               put_text(pick_quoted_char());
            end
         end
         if (!cut) put_text(CH_QUOTE);
      end else begin
         put_text(pick_word_char());
         repeat ($urandom_range(5)) put_text(pick_value_char());
      end
      if (!cut) put_line_end();
   endtask

   task automatic put_document();
      int lines;
      int pick;
      doc_broken = 1'b0;
      lines = $urandom_range(6, 1);
      for (int i = 0; i < lines; i++) begin
         pick = $urandom_range(9);
         if (pick <= 1) begin
            put_text(CH_OPEN);
            repeat ($urandom_range(4)) put_text(pick_alnum());
            put_text(CH_CLOSE);
            put_line_end();
         end else if (pick <= 6) begin
            put_setting(i == lines - 1);
         end else if (pick == 7) begin
            put_spaces(0, 1);
            put_comment();
            put_text(CH_NEWLINE);
         end else if (pick == 8) begin
            put_spaces(0, 3);
            put_text(CH_NEWLINE);
         end else begin
            repeat ($urandom_range(3, 1)) send_item(ACT_BYTE, 8'($urandom_range(255)));
            doc_broken = 1'b1;
         end
      end
      send_item(ACT_EOS, 8'($urandom_range(255)));
   endtask

   // result side pacing, with one long hold-off on request
   initial begin
      wait (!reset);
      forever begin
         if (rx_hold_req) begin
            pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rx_hold_req = 1'b0;
         end else begin
            pop <= ($urandom_range(99) >= rx_idle);
            @(posedge clock);
         end
      end
   end

   initial begin
      bit hold_done;
      hold_done = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed text
      put_string("[a]\n");
      put_string("k=v");
      send_item(ACT_EOS, 8'hFF);
      put_string("n=\"\\\"");
      send_item(ACT_EOS, 8'h00);
      send_item(ACT_BYTE, CH_TAB);
      send_item(ACT_BYTE, CH_VT);
      send_item(ACT_BYTE, CH_FF);
      send_item(ACT_BYTE, CH_CR);
      send_item(ACT_BYTE, 8'hFF);
      send_item(ACT_BYTE, 8'h00);
      send_item(ACT_BYTE, CH_NEWLINE);
      send_item(ACT_EOS, 8'h5A);
      put_string("x\n");
      send_item(ACT_EOS, 8'hA5);
      drain();

      for (int p = 0; p < 3; p++) begin
         tx_idle = (p == 0) ? 19 : (p == 1) ? 53 : 0;
         rx_idle = (p == 0) ? 53 : (p == 1) ? 19 : 0;
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            if (!hold_done && phase_items > 100) begin
               rx_hold_req = 1'b1;
               hold_done = 1'b1;
            end
            put_document();
         end
         drain();
      end

      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/ict_pkg.sv
rtl/ict_queue.sv
rtl/ict_front.sv
rtl/ict_back.sv
rtl/ini_config_tokenizer_core.sv
tb/ini_config_tokenizer_checker.sv
tb/ini_config_tokenizer_core_tb.sv
